/* hdl/tmpw_pkg.sv */
// Shared types and constants for the tetrahedral mesh point walk unit.
package tmpw_pkg;

    // input word commands
    localparam logic [1:0] CMD_NODE  = 2'd0;
    localparam logic [1:0] CMD_CORN  = 2'd1;
    localparam logic [1:0] CMD_NBR   = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // configuration register select (paddr bit 2)
    localparam logic REG_EPS   = 1'b0;
    localparam logic REG_ELEMS = 1'b1;

    localparam logic [15:0] EPS_RESET   = 16'd66;
    localparam logic [12:0] ELEMS_RESET = 13'd4096;

    // multiplier operand select
    localparam logic [1:0] MUL_BC = 2'd0;
    localparam logic [1:0] MUL_CB = 2'd1;
    localparam logic [1:0] MUL_AX = 2'd2;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_CLR  = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

    typedef struct packed {
        logic       take;
        logic       q_ld;
        logic       corn_rd;
        logic       node_rd;
        logic [1:0] node_slot;
        logic       node_cap;
        logic [1:0] cap_slot;
        logic [2:0] det_sel;
        logic [1:0] axis;
        logic [1:0] mul_sel;
        logic       prod_en;
        logic       tmp_ld;
        logic       cross_ld;
        logic [1:0] acc_op;
        logic       det_st;
        logic       eps_ld;
        logic       elem_mv;
        logic       step_inc;
        logic       res_ld;
        logic       res_inside;
    } t_ctl;

    typedef struct packed {
        logic in_query;
        logic stop_top;
        logic s_zero;
        logic all_ok;
        logic can_move;
        logic out_free;
    } t_sts;

endpackage

/* hdl/tmpw_if.sv */
// Valid/ready channel interfaces for input and result words.
interface tmpw_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [11:0]        index;
    logic [1:0]         slot;
    logic signed [12:0] link;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;

    modport source (output valid, cmd, index, slot, link, px, py, pz, input ready);
    modport sink (input valid, cmd, index, slot, link, px, py, pz, output ready);
endinterface

interface tmpw_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] steps_taken;
    logic [11:0] found_element;
    logic        inside_res;

    modport source (output valid, steps_taken, found_element, inside_res, input ready);
    modport sink (input valid, steps_taken, found_element, inside_res, output ready);
endinterface

/* hdl/tmpw_dp.sv */
// Datapath: mesh tables, determinant engine, weight tests and result register.
module tmpw_dp #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_ELEMS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmpw_pkg::t_ctl     i_ctl,
    output tmpw_pkg::t_sts     o_sts,
    input  logic [1:0]         i_cmd,
    input  logic [11:0]        i_index,
    input  logic [1:0]         i_slot,
    input  logic signed [12:0] i_link,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic signed [15:0] i_pz,
    input  logic [15:0]        i_eps,
    input  logic [12:0]        i_elem_count,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [12:0]        o_steps,
    output logic [11:0]        o_found,
    output logic               o_inside
);
    import tmpw_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    t_point             r_q;
    logic [11:0]        r_elem;
    logic [12:0]        r_step;
    logic [NW-1:0]      r_corn_q [4];
    logic signed [12:0] r_nbr_q [4];
    logic [47:0]        r_node_q;
    t_point             r_pt [4];
    logic signed [34:0] r_tmp;
    logic signed [34:0] r_cross;
    logic signed [51:0] r_prod;
    logic signed [52:0] r_acc;
    logic signed [52:0] r_s;
    logic signed [52:0] r_num [4];
    logic [67:0]        r_epsprod;
    logic               r_out_valid;
    logic [12:0]        r_res_steps;
    logic [11:0]        r_res_found;
    logic               r_res_inside;

    logic          w_node_we, w_corn_we, w_nbr_we;
    logic [EW-1:0] w_waddr, w_raddr;
    logic [47:0]   m_node [MAX_NODES];

    assign w_node_we = i_ctl.take && (i_cmd == CMD_NODE) && (32'(i_index) < MAX_NODES);
    assign w_corn_we = i_ctl.take && (i_cmd == CMD_CORN) && (32'(i_index) < MAX_ELEMS)
                       && !i_link[12] && (32'(i_link[11:0]) < MAX_NODES);
    assign w_nbr_we  = i_ctl.take && (i_cmd == CMD_NBR) && (32'(i_index) < MAX_ELEMS);
    assign w_waddr   = EW'(i_index);
    assign w_raddr   = EW'(r_elem);

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            m_node[NW'(i_index)] <= {i_px, i_py, i_pz};
        end
        if (i_ctl.node_rd) begin
            r_node_q <= m_node[r_corn_q[i_ctl.node_slot]];
        end
    end

    // one corner table and one neighbor table per slot
    for (genvar g = 0; g < 4; g++) begin : g_slot
        logic [NW-1:0]      m_corn [MAX_ELEMS];
        logic signed [12:0] m_nbr [MAX_ELEMS];
        always_ff @(posedge i_clk) begin
            if (w_corn_we && (i_slot == 2'(g))) begin
                m_corn[w_waddr] <= NW'(i_link[11:0]);
            end
            if (w_nbr_we && (i_slot == 2'(g))) begin
                m_nbr[w_waddr] <= i_link;
            end
            if (i_ctl.corn_rd) begin
                r_corn_q[g] <= m_corn[w_raddr];
                r_nbr_q[g]  <= m_nbr[w_raddr];
            end
        end
    end

    // determinant operands: corner det_sel-1 replaced by the query point
    t_point             w_v [4];
    logic signed [16:0] w_d [3][3];
    logic [1:0]         w_j1, w_j2;
    logic signed [34:0] w_opa;
    logic signed [16:0] w_opb;
    logic signed [51:0] w_mul;
    logic signed [52:0] w_abs_s;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_v[i] = (i_ctl.det_sel == 3'(i + 1)) ? r_q : r_pt[i];
        end
        for (int k = 0; k < 3; k++) begin
            w_d[k][0] = 17'(w_v[k+1].x) - 17'(w_v[0].x);
            w_d[k][1] = 17'(w_v[k+1].y) - 17'(w_v[0].y);
            w_d[k][2] = 17'(w_v[k+1].z) - 17'(w_v[0].z);
        end
    end

    assign w_j1 = (i_ctl.axis == 2'd2) ? 2'd0 : i_ctl.axis + 2'd1;
    assign w_j2 = (i_ctl.axis == 2'd0) ? 2'd2 : i_ctl.axis - 2'd1;

    always_comb begin
        unique case (i_ctl.mul_sel)
            MUL_BC: begin
                w_opa = 35'(w_d[1][w_j1]);
                w_opb = w_d[2][w_j2];
            end
            MUL_CB: begin
                w_opa = 35'(w_d[1][w_j2]);
                w_opb = w_d[2][w_j1];
            end
            default: begin
                w_opa = r_cross;
                w_opb = w_d[0][i_ctl.axis];
            end
        endcase
    end

    assign w_mul   = 52'(w_opa) * 52'(w_opb);
    assign w_abs_s = r_s[52] ? -r_s : r_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= w_mul;
        end
        if (i_ctl.tmp_ld) begin
            r_tmp <= r_prod[34:0];
        end
        if (i_ctl.cross_ld) begin
            r_cross <= r_tmp - r_prod[34:0];
        end
        unique case (i_ctl.acc_op)
            ACC_CLR:  r_acc <= '0;
            ACC_ADD:  r_acc <= r_acc + 53'(r_prod);
            default:  r_acc <= r_acc;
        endcase
        if (i_ctl.det_st) begin
            if (i_ctl.det_sel == 3'd0) begin
                r_s <= r_acc;
            end else begin
                r_num[2'(i_ctl.det_sel - 3'd1)] <= r_s[52] ? -r_acc : r_acc;
            end
        end
        if (i_ctl.eps_ld) begin
            r_epsprod <= 68'(w_abs_s[51:0]) * 68'(i_eps);
        end
        if (i_ctl.node_cap) begin
            r_pt[i_ctl.cap_slot] <= t_point'(r_node_q);
        end
        if (i_ctl.q_ld) begin
            r_q <= '{x: i_px, y: i_py, z: i_pz};
        end
    end

    // weight tests: num*2^16 + eps*|s| >= 0
    logic [3:0]         w_ok;
    logic [69:0]        w_sum [4];
    logic signed [52:0] w_mn01, w_mn23, w_mn;
    logic               w_move;
    logic [11:0]        w_next;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_sum[c] = {r_num[c][52], r_num[c], 16'd0} + {2'd0, r_epsprod};
            w_ok[c]  = !w_sum[c][69];
        end
    end

    assign w_mn01 = (r_num[0] <= r_num[1]) ? r_num[0] : r_num[1];
    assign w_mn23 = (r_num[2] <= r_num[3]) ? r_num[2] : r_num[3];
    assign w_mn   = (w_mn01 <= w_mn23) ? w_mn01 : w_mn23;

    // first face at the minimum that has a real neighbor
    always_comb begin
        w_move = 1'b0;
        w_next = r_elem;
        for (int c = 0; c < 4; c++) begin
            if (!w_move && (r_num[c] == w_mn) && !r_nbr_q[c][12]
                && (32'(r_nbr_q[c][11:0]) < MAX_ELEMS)) begin
                w_move = 1'b1;
                w_next = r_nbr_q[c][11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.q_ld) begin
            r_elem <= i_index;
            r_step <= '0;
        end else begin
            if (i_ctl.elem_mv) begin
                r_elem <= w_next;
            end
            if (i_ctl.step_inc) begin
                r_step <= r_step + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.res_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_ld) begin
            r_res_steps  <= r_step;
            r_res_found  <= r_elem;
            r_res_inside <= i_ctl.res_inside;
        end
    end

    assign o_sts.in_query = (i_cmd == CMD_QUERY);
    assign o_sts.stop_top = !(32'(r_elem) < MAX_ELEMS) || (r_step >= i_elem_count);
    assign o_sts.s_zero   = (r_s == '0);
    assign o_sts.all_ok   = &w_ok;
    assign o_sts.can_move = w_move;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_steps     = r_res_steps;
    assign o_found     = r_res_found;
    assign o_inside    = r_res_inside;

endmodule

/* hdl/tmpw_ctrl.sv */
// Controller: sequences loads, element fetch, determinant steps and the walk.
module tmpw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tmpw_pkg::t_sts i_sts,
    output tmpw_pkg::t_ctl o_ctl
);
    import tmpw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TOP  = 3'd1;
    localparam logic [2:0] ST_NODE = 3'd2;
    localparam logic [2:0] ST_DET  = 3'd3;
    localparam logic [2:0] ST_EVAL = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [3:0] U_FIN   = 4'd12;
    localparam logic [3:0] U_STORE = 4'd13;
    localparam logic [2:0] DET_LAST = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_det, n_det;
    logic       r_inside, n_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_det    <= '0;
            r_inside <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_det    <= n_det;
            r_inside <= n_inside;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_det      = r_det;
        n_inside   = r_inside;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    if (i_sts.in_query) begin
                        o_ctl.q_ld = 1'b1;
                        n_state    = ST_TOP;
                    end
                end
            end
            ST_TOP: begin
                if (i_sts.stop_top) begin
                    n_inside = 1'b0;
                    n_state  = ST_DONE;
                end else begin
                    o_ctl.corn_rd = 1'b1;
                    n_cnt         = '0;
                    n_state       = ST_NODE;
                end
            end
            ST_NODE: begin
                // read node k while capturing node k-1
                o_ctl.node_rd   = (r_cnt < 4'd4);
                o_ctl.node_slot = r_cnt[1:0];
                o_ctl.node_cap  = (r_cnt != 4'd0);
                o_ctl.cap_slot  = 2'(r_cnt - 4'd1);
                if (r_cnt == 4'd4) begin
                    n_cnt   = '0;
                    n_det   = '0;
                    n_state = ST_DET;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_DET: begin
                o_ctl.det_sel = r_det;
                o_ctl.axis    = r_cnt[3:2];
                n_cnt         = r_cnt + 4'd1;
                priority if ((r_det == 3'd1) && (r_cnt == 4'd0) && i_sts.s_zero) begin
                    n_inside = 1'b0;
                    n_state  = ST_DONE;
                end else if (r_cnt < U_FIN) begin
                    o_ctl.eps_ld = (r_det == 3'd1) && (r_cnt == 4'd0);
                    unique case (r_cnt[1:0])
                        2'd0: begin
                            o_ctl.mul_sel = MUL_BC;
                            o_ctl.prod_en = 1'b1;
                            o_ctl.acc_op  = (r_cnt[3:2] == 2'd0) ? ACC_CLR : ACC_ADD;
                        end
                        2'd1: begin
                            o_ctl.tmp_ld  = 1'b1;
                            o_ctl.mul_sel = MUL_CB;
                            o_ctl.prod_en = 1'b1;
                        end
                        2'd2: begin
                            o_ctl.cross_ld = 1'b1;
                        end
                        default: begin
                            o_ctl.mul_sel = MUL_AX;
                            o_ctl.prod_en = 1'b1;
                        end
                    endcase
                end else if (r_cnt == U_FIN) begin
                    o_ctl.acc_op = ACC_ADD;
                end else begin
                    o_ctl.det_st = 1'b1;
                    n_cnt        = '0;
                    if (r_det == DET_LAST) begin
                        n_state = ST_EVAL;
                    end else begin
                        n_det = r_det + 3'd1;
                    end
                end
            end
            ST_EVAL: begin
                priority if (i_sts.all_ok) begin
                    n_inside = 1'b1;
                    n_state  = ST_DONE;
                end else if (i_sts.can_move) begin
                    o_ctl.elem_mv  = 1'b1;
                    o_ctl.step_inc = 1'b1;
                    n_state        = ST_TOP;
                end else begin
                    n_inside = 1'b0;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.res_ld     = 1'b1;
                    o_ctl.res_inside = r_inside;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/tetra_mesh_point_walk_unit.sv */
// Top level: APB registers, channel wiring, controller and datapath.
// Load words (node, corner, neighbor) are taken while idle and give no result.
// A query walks elements; each walk step is an element fetch, five 3x3
// determinants on the one shared multiplier, and a weight test.
// One query is in work at a time.
// Synchronous active-low reset clears control state and restores eps_q16 and
// elem_count to their defaults; mesh tables are not cleared.
module tetra_mesh_point_walk_unit #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_ELEMS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmpw_in_if.sink     i_in,
    tmpw_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tmpw_pkg::*;

    logic [15:0] r_eps;
    logic [12:0] r_elems;
    t_ctl        w_ctl;
    t_sts        w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps   <= EPS_RESET;
            r_elems <= ELEMS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_EPS) begin
                r_eps <= pwdata[15:0];
            end else begin
                r_elems <= pwdata[12:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ELEMS) ? {19'd0, r_elems} : {16'd0, r_eps};

    tmpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    tmpw_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cmd        (i_in.cmd),
        .i_index      (i_in.index),
        .i_slot       (i_in.slot),
        .i_link       (i_in.link),
        .i_px         (i_in.px),
        .i_py         (i_in.py),
        .i_pz         (i_in.pz),
        .i_eps        (r_eps),
        .i_elem_count (r_elems),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_steps      (o_out.steps_taken),
        .o_found      (o_out.found_element),
        .o_inside     (o_out.inside_res)
    );

endmodule

/* hdl/tmpw_chk.sv */
// Port-level checker for the walk unit, bound to the top level.
module tmpw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [12:0] i_steps,
    input logic [11:0] i_found,
    input logic        i_inside
);
    import tmpw_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_steps)
        && $stable(i_found) && $stable(i_inside))
        else $error("result word changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // walking blocks further input
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_QUERY) |=> !i_in_ready)
        else $error("input taken during a walk");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd != CMD_QUERY) && !i_out_valid
        |=> !i_out_valid)
        else $error("load word produced a result");

endmodule

bind tetra_mesh_point_walk_unit tmpw_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_steps     (o_out.steps_taken),
    .i_found     (o_out.found_element),
    .i_inside    (o_out.inside_res)
);

/* tb/tetra_mesh_point_walk_unit_tb.sv */
// Self-checking testbench for the tetrahedral mesh point walk unit.
module tetra_mesh_point_walk_unit_tb;
    import tmpw_pkg::*;

    localparam int NODES = 1024;
    localparam int ELEMS = 4096;
    localparam int SET_ELEMS = 12;     // elements 0..11 form the random test mesh
    localparam int SET_NODES = 16;     // nodes 0..15 are its corners
    localparam int DEGEN_ELEM = 12;    // element with a repeated corner
    localparam logic [2:0] ADDR_EPS   = {REG_EPS, 2'b00};
    localparam logic [2:0] ADDR_ELEMS = {REG_ELEMS, 2'b00};

    typedef struct packed {
        logic [12:0] steps;
        logic [11:0] elem;
        logic        hit;
    } t_walk_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    tmpw_in_if  in_ch();
    tmpw_out_if out_ch();

    tetra_mesh_point_walk_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's tables and registers
    logic signed [15:0] node_x [NODES];
    logic signed [15:0] node_y [NODES];
    logic signed [15:0] node_z [NODES];
    logic [9:0]         corner [ELEMS][4];
    logic signed [12:0] nbr    [ELEMS][4];
    logic [15:0]        eps_cfg;
    logic [12:0]        limit_cfg;

    t_walk_res pending_walks[$];
    int        errors;
    bit        quiet;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint trip(longint x[4], longint y[4], longint z[4],
                                    int p, int q, int r);
        return x[p] * (y[q] * z[r] - z[q] * y[r])
             - y[p] * (x[q] * z[r] - z[q] * x[r])
             + z[p] * (x[q] * y[r] - y[q] * x[r]);
    endfunction

    function automatic longint vol4(longint x[4], longint y[4], longint z[4]);
        return trip(x, y, z, 1, 2, 3) - trip(x, y, z, 0, 2, 3)
             + trip(x, y, z, 0, 1, 3) - trip(x, y, z, 0, 1, 2);
    endfunction

    // num/|s| >= -eps without division: |num|*2^16 <= eps*|s| for negative num
    function automatic bit weight_ok(longint num, longint abs_s);
        logic [127:0] lhs, rhs;
        if (num >= 0) return 1'b1;
        lhs = 128'(-num) << 16;
        rhs = 128'(abs_s) * 128'(eps_cfg);
        return lhs <= rhs;
    endfunction

    function automatic t_walk_res locate(logic [11:0] start, logic signed [15:0] qx,
                                         logic signed [15:0] qy, logic signed [15:0] qz);
        longint x[4], y[4], z[4], tx[4], ty[4], tz[4], num[4];
        longint s, sg, mn;
        int e, k;
        bit all_ok, moved;
        t_walk_res r;
        e = start;
        k = 0;
        r.hit = 1'b0;
        while (k < limit_cfg) begin
            for (int c = 0; c < 4; c++) begin
                x[c] = node_x[corner[e][c]];
                y[c] = node_y[corner[e][c]];
                z[c] = node_z[corner[e][c]];
            end
            s = vol4(x, y, z);
            if (s == 0) break;
            sg = (s > 0) ? 1 : -1;
            all_ok = 1'b1;
            for (int c = 0; c < 4; c++) begin
                tx = x; ty = y; tz = z;
                tx[c] = qx; ty[c] = qy; tz[c] = qz;
                num[c] = vol4(tx, ty, tz) * sg;
                if (!weight_ok(num[c], s * sg)) all_ok = 1'b0;
            end
            if (all_ok) begin
                r.hit = 1'b1;
                break;
            end
            mn = num[0];
            for (int c = 1; c < 4; c++) if (num[c] < mn) mn = num[c];
            moved = 1'b0;
            for (int c = 0; c < 4; c++) begin
                if (!moved && num[c] == mn && nbr[e][c] >= 0) begin
                    e = nbr[e][c];
                    moved = 1'b1;
                end
            end
            if (!moved) break;
            k++;
        end
        r.steps = 13'(k);
        r.elem = 12'(e);
        return r;
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [11:0] idx, logic [1:0] slot,
                             logic signed [12:0] link, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.cmd = cmd; in_ch.index = idx; in_ch.slot = slot; in_ch.link = link;
        in_ch.px = x; in_ch.py = y; in_ch.pz = z;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        case (cmd)
            CMD_NODE: if (idx < NODES) begin
                node_x[idx] = x; node_y[idx] = y; node_z[idx] = z;
            end
            CMD_CORN: if (link >= 0 && link < NODES) corner[idx][slot] = link[9:0];
            CMD_NBR:  nbr[idx][slot] = link;
            CMD_QUERY: pending_walks.push_back(locate(idx, x, y, z));
        endcase
        @(negedge i_clk);
    endtask

    task automatic idle_wait();
        in_ch.valid = 1'b0;
        while (pending_walks.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_EPS) eps_cfg = data[15:0];
        else limit_cfg = data[12:0];
    endtask

    task automatic query_rand(logic [11:0] e);
        send_word(CMD_QUERY, e, 2'($urandom), 13'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // point at the center of an element, coordinates truncated by the integer division
    task automatic query_center(logic [11:0] e);
        int sx, sy, sz;
        sx = 0; sy = 0; sz = 0;
        for (int c = 0; c < 4; c++) begin
            sx += node_x[corner[e][c]];
            sy += node_y[corner[e][c]];
            sz += node_z[corner[e][c]];
        end
        send_word(CMD_QUERY, e, 2'($urandom), 13'($urandom),
                  16'(sx / 4), 16'(sy / 4), 16'(sz / 4));
    endtask

    task automatic test_load_mesh();
        for (int n = 0; n < SET_NODES; n++)
            send_word(CMD_NODE, 12'(n), 2'($urandom), 13'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        for (int e = 0; e < SET_ELEMS; e++)
            for (int s = 0; s < 4; s++) begin
                send_word(CMD_CORN, 12'(e), 2'(s), 13'($urandom_range(0, SET_NODES - 1)),
                          16'($urandom), 16'($urandom), 16'($urandom));
                send_word(CMD_NBR, 12'(e), 2'(s),
                          ($urandom_range(0, 3) == 0) ? -13'sd1
                                                      : 13'($urandom_range(0, SET_ELEMS - 1)),
                          16'($urandom), 16'($urandom), 16'($urandom));
            end
        // corner repeated: zero volume
        for (int s = 0; s < 4; s++) begin
            send_word(CMD_CORN, 12'(DEGEN_ELEM), 2'(s), (s == 0) ? 13'sd1 : 13'(s),
                      16'sd0, 16'sd0, 16'sd0);
            send_word(CMD_NBR, 12'(DEGEN_ELEM), 2'(s), 13'sd0, 16'sd0, 16'sd0, 16'sd0);
        end
        // ignored writes and an unusual boundary marker
        send_word(CMD_NODE, 12'd4095, 2'd3, 13'sd0, 16'sh7fff, -16'sh8000, 16'sh7fff);
        send_word(CMD_NODE, 12'd1024, 2'd0, 13'sd0, 16'sh1234, 16'sh1234, 16'sh1234);
        send_word(CMD_CORN, 12'd0, 2'd0, -13'sd5, 16'sd0, 16'sd0, 16'sd0);
        send_word(CMD_CORN, 12'd0, 2'd1, 13'sd4095, 16'sd0, 16'sd0, 16'sd0);
        send_word(CMD_NBR, 12'd1, 2'd2, -13'sd4096, 16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_defaults();
        for (int e = 0; e < 4; e++) query_center(12'(e));
        query_center(12'(DEGEN_ELEM));
        send_word(CMD_QUERY, 12'd0, 2'd0, 13'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_word(CMD_QUERY, 12'd5, 2'd3, -13'sd1, -16'sh8000, -16'sh8000, -16'sh8000);
    endtask

    task automatic test_eps_extremes();
        idle_wait();
        reg_write(ADDR_EPS, 32'd0);
        reg_write(ADDR_ELEMS, 32'd8);
        for (int i = 0; i < 4; i++) query_rand(12'($urandom_range(0, SET_ELEMS - 1)));
        query_center(12'd2);
        idle_wait();
        reg_write(ADDR_EPS, 32'hffff);
        for (int i = 0; i < 4; i++) query_rand(12'($urandom_range(0, SET_ELEMS - 1)));
    endtask

    task automatic test_step_limit();
        idle_wait();
        reg_write(ADDR_EPS, 32'd66);
        reg_write(ADDR_ELEMS, 32'd1);
        for (int i = 0; i < 4; i++) query_rand(12'($urandom_range(0, SET_ELEMS - 1)));
        idle_wait();
        reg_write(ADDR_ELEMS, 32'd4096);
        query_center(12'd7);
        query_rand(12'd3);
    endtask

    task automatic random_word();
        int r;
        logic [11:0] e;
        r = $urandom_range(0, 99);
        e = 12'($urandom_range(0, SET_ELEMS - 1));
        if (r < 25) query_rand(e);
        else if (r < 45) query_center(e);
        else if (r < 58)
            send_word(CMD_NODE, 12'($urandom_range(0, SET_NODES - 1)), 2'($urandom),
                      13'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 70)
            send_word(CMD_CORN, e, 2'($urandom), 13'($urandom_range(0, SET_NODES - 1)),
                      16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 84)
            send_word(CMD_NBR, e, 2'($urandom),
                      ($urandom_range(0, 3) == 0) ? -13'($urandom_range(1, 4096))
                                                  : 13'($urandom_range(0, SET_ELEMS - 1)),
                      16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 90)  // tables outside the mesh in use, never queried
            send_word(CMD_NODE, 12'($urandom_range(SET_NODES, 4095)), 2'($urandom),
                      13'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 95)
            send_word(CMD_NBR, 12'($urandom_range(DEGEN_ELEM + 1, 4095)), 2'($urandom),
                      13'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_word(CMD_CORN, ($urandom_range(0, 1) == 0) ? e
                                    : 12'($urandom_range(DEGEN_ELEM + 1, 4095)),
                      2'($urandom), -13'($urandom_range(1, 4096)),
                      16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            idle_wait();
            reg_write(ADDR_EPS, (ph == 0) ? 32'd0 : 32'($urandom_range(0, 65535)));
            reg_write(ADDR_ELEMS, 32'($urandom_range(1, 16)));
            quiet = (ph == 2);
            for (int i = 0; i < 70; i++) random_word();
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls per word
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_walk_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_walks.size() == 0) begin
                $display("%0t: unexpected word steps=%0d elem=%0d inside=%0b", $time,
                         out_ch.steps_taken, out_ch.found_element, out_ch.inside_res);
                errors++;
            end else begin
                want = pending_walks.pop_front();
                if (out_ch.steps_taken !== want.steps) begin
                    $display("%0t: steps_taken exp %0d got %0d", $time, want.steps,
                             out_ch.steps_taken);
                    errors++;
                end
                if (out_ch.found_element !== want.elem) begin
                    $display("%0t: found_element exp %0d got %0d", $time, want.elem,
                             out_ch.found_element);
                    errors++;
                end
                if (out_ch.inside_res !== want.hit) begin
                    $display("%0t: inside_res exp %0b got %0b", $time, want.hit,
                             out_ch.inside_res);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        quiet = 1'b0;
        eps_cfg = EPS_RESET;
        limit_cfg = ELEMS_RESET;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.cmd = CMD_NODE; in_ch.index = '0; in_ch.slot = '0;
        in_ch.link = '0; in_ch.px = '0; in_ch.py = '0; in_ch.pz = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_load_mesh();
        test_defaults();
        test_eps_extremes();
        test_step_limit();
        test_random();
        idle_wait();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
